/* hdl/rvx_pkg.sv */
// Shared types, codes and constants of the RV32I subset execute unit.
package rvx_pkg;

    localparam int NUM_REGS_DEF = 32;
    localparam int XLEN = 32;
    localparam int REG_IDX_W = 5;
    localparam int SHAMT_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam logic [XLEN-1:0] IO_ADDRESS_RESET = 32'h2000_0000;
    localparam logic [XLEN-1:0] START_PC_RESET = 32'h0000_0000;
    localparam logic [XLEN-1:0] INSTR_BYTES = 32'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_IO_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PC = 1'b1;

    localparam logic [6:0] OP_REG = 7'h33;
    localparam logic [6:0] OP_IMM = 7'h13;
    localparam logic [6:0] OP_LUI = 7'h37;
    localparam logic [6:0] OP_AUIPC = 7'h17;
    localparam logic [6:0] OP_JAL = 7'h6f;
    localparam logic [6:0] OP_JALR = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD = 7'h03;
    localparam logic [6:0] OP_STORE = 7'h23;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SRX = 3'd5;
    localparam logic [2:0] F3_OR = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;
    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [2:0] F3_BLT = 3'd4;
    localparam logic [2:0] F3_BGE = 3'd5;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_JALR = 3'd0;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT = 7'h20;

    typedef enum logic [2:0] {
        ST_EXECUTED = 3'd0,
        ST_LOAD_REQ = 3'd1,
        ST_STORE    = 3'd2,
        ST_ILLEGAL  = 3'd3,
        ST_LOAD_WR  = 3'd4,
        ST_IGNORED  = 3'd5
    } t_status;

    typedef struct packed {
        t_status                status;
        logic [XLEN-1:0]        mem_address;
        logic [XLEN-1:0]        store_data;
        logic                   io_access;
        logic [XLEN-1:0]        new_pc;
        logic [REG_IDX_W-1:0]   dest_index;
        logic [XLEN-1:0]        dest_value;
        logic                   pc_we;
        logic                   rf_we;
        logic                   load_set;
        logic                   load_clr;
        logic [REG_IDX_W-1:0]   pend_dest;
    } t_exec_res;

endpackage

/* hdl/rvx_in_if.sv */
// Request channel carrying instruction and load-return items.
interface rvx_in_if;
    import rvx_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [XLEN-1:0]        instr_word;
    logic signed [XLEN-1:0] load_data;

    modport source (output valid, mode, instr_word, load_data, input ready);
    modport sink (input valid, mode, instr_word, load_data, output ready);
endinterface

/* hdl/rvx_out_if.sv */
// Result channel carrying one result per executed request.
interface rvx_out_if;
    import rvx_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [XLEN-1:0]           mem_address;
    logic signed [XLEN-1:0]    store_data;
    logic                      io_access;
    logic [XLEN-1:0]           new_pc;
    logic [REG_IDX_W-1:0]      dest_index;
    logic signed [XLEN-1:0]    dest_value;

    modport source (output valid, status, mem_address, store_data, io_access, new_pc,
                    dest_index, dest_value, input ready);
    modport sink (input valid, status, mem_address, store_data, io_access, new_pc,
                  dest_index, dest_value, output ready);
endinterface

/* hdl/rvx_regfile.sv */
// Register file memory with two registered read ports, valid bits and write forwarding.
module rvx_regfile
    import rvx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [REG_IDX_W-1:0]  i_rs1_idx,
    input  logic [REG_IDX_W-1:0]  i_rs2_idx,
    input  logic                  i_wr_en,
    input  logic [REG_IDX_W-1:0]  i_wr_idx,
    input  logic [XLEN-1:0]       i_wr_data,
    output logic [XLEN-1:0]       o_rs1_val,
    output logic [XLEN-1:0]       o_rs2_val
);

    localparam int ADDR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [XLEN-1:0]      r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]  r_valid;
    logic [XLEN-1:0]      r_rd1;
    logic [XLEN-1:0]      r_rd2;
    logic [REG_IDX_W-1:0] r_rs1_idx;
    logic [REG_IDX_W-1:0] r_rs2_idx;
    logic                 r_fwd_en;
    logic [REG_IDX_W-1:0] r_fwd_idx;
    logic [XLEN-1:0]      r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx[ADDR_W-1:0]] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd1 <= r_mem[i_rs1_idx[ADDR_W-1:0]];
            r_rd2 <= r_mem[i_rs2_idx[ADDR_W-1:0]];
            r_rs1_idx <= i_rs1_idx;
            r_rs2_idx <= i_rs2_idx;
        end
        if (i_wr_en) begin
            r_fwd_idx <= i_wr_idx;
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fwd_en <= 1'b0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx[ADDR_W-1:0]] <= 1'b1;
            r_fwd_en <= 1'b1;
        end
    end

    function automatic logic [XLEN-1:0] sel_val(
        input logic [REG_IDX_W-1:0] idx,
        input logic [XLEN-1:0]      mem_val,
        input logic                 fwd_en,
        input logic [REG_IDX_W-1:0] fwd_idx,
        input logic [XLEN-1:0]      fwd_data,
        input logic [NUM_REGS-1:0]  valid
    );
        logic [XLEN-1:0] v;
        v = '0;
        if (idx != '0 && 32'(idx) < 32'(NUM_REGS)) begin
            if (fwd_en && fwd_idx == idx) begin
                v = fwd_data;
            end else if (valid[idx[ADDR_W-1:0]]) begin
                v = mem_val;
            end
        end
        return v;
    endfunction

    assign o_rs1_val = sel_val(r_rs1_idx, r_rd1, r_fwd_en, r_fwd_idx, r_fwd_data, r_valid);
    assign o_rs2_val = sel_val(r_rs2_idx, r_rd2, r_fwd_en, r_fwd_idx, r_fwd_data, r_valid);

endmodule

/* hdl/rvx_exec.sv */
// Decode, ALU, branch and address logic of one instruction or load-return request.
module rvx_exec
    import rvx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic                  i_mode,
    input  logic [XLEN-1:0]       i_instr,
    input  logic [XLEN-1:0]       i_load_data,
    input  logic [XLEN-1:0]       i_rs1_val,
    input  logic [XLEN-1:0]       i_rs2_val,
    input  logic [XLEN-1:0]       i_pc,
    input  logic [XLEN-1:0]       i_io_address,
    input  logic                  i_load_waiting,
    input  logic [REG_IDX_W-1:0]  i_pending_dest,
    output t_exec_res             o_res
);

    logic [6:0]           op;
    logic [2:0]           f3;
    logic [6:0]           f7;
    logic [6:0]           f7_alu;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rs1;
    logic [REG_IDX_W-1:0] rs2;
    logic [XLEN-1:0]      immi;
    logic [XLEN-1:0]      imms;
    logic [XLEN-1:0]      immb;
    logic [XLEN-1:0]      immj;
    logic [XLEN-1:0]      seq_pc;
    logic [XLEN-1:0]      alu_b;
    logic [SHAMT_W-1:0]   sh;
    logic                 imm_form;
    logic                 alu_ok;
    logic [XLEN-1:0]      alu_res;
    logic                 ok_rd;
    logic                 ok_rs1;
    logic                 ok_rs2;
    logic                 take;
    logic                 legal;
    logic                 wr;
    logic [XLEN-1:0]      res;
    logic [XLEN-1:0]      npc;
    logic [XLEN-1:0]      addr;

    assign op = i_instr[6:0];
    assign rd = i_instr[11:7];
    assign f3 = i_instr[14:12];
    assign rs1 = i_instr[19:15];
    assign rs2 = i_instr[24:20];
    assign f7 = i_instr[31:25];
    assign immi = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imms = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign immb = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                   i_instr[11:8], 1'b0};
    assign immj = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                   i_instr[30:21], 1'b0};
    assign seq_pc = i_pc + INSTR_BYTES;
    assign ok_rd = 32'(rd) < 32'(NUM_REGS);
    assign ok_rs1 = 32'(rs1) < 32'(NUM_REGS);
    assign ok_rs2 = 32'(rs2) < 32'(NUM_REGS);

    assign imm_form = (op == OP_IMM);
    assign alu_b = imm_form ? immi : i_rs2_val;
    assign sh = alu_b[SHAMT_W-1:0];
    assign f7_alu = (imm_form && f3 != F3_SLL && f3 != F3_SRX) ? F7_BASE : f7;

    always_comb begin
        alu_ok = 1'b0;
        alu_res = '0;
        case (f3)
            F3_ADD: begin
                if (imm_form || f7_alu == F7_BASE) begin
                    alu_ok = 1'b1;
                    alu_res = i_rs1_val + alu_b;
                end else if (f7_alu == F7_ALT) begin
                    alu_ok = 1'b1;
                    alu_res = i_rs1_val - alu_b;
                end
            end
            F3_SLL: begin
                alu_ok = (f7_alu == F7_BASE);
                alu_res = i_rs1_val << sh;
            end
            F3_SLT: begin
                alu_ok = (f7_alu == F7_BASE);
                alu_res = {31'b0, $signed(i_rs1_val) < $signed(alu_b)};
            end
            F3_XOR: begin
                alu_ok = (f7_alu == F7_BASE);
                alu_res = i_rs1_val ^ alu_b;
            end
            F3_SRX: begin
                if (f7_alu == F7_BASE) begin
                    alu_ok = 1'b1;
                    alu_res = i_rs1_val >> sh;
                end else if (f7_alu == F7_ALT) begin
                    alu_ok = 1'b1;
                    alu_res = $unsigned($signed(i_rs1_val) >>> sh);
                end
            end
            F3_OR: begin
                alu_ok = (f7_alu == F7_BASE);
                alu_res = i_rs1_val | alu_b;
            end
            F3_AND: begin
                alu_ok = (f7_alu == F7_BASE);
                alu_res = i_rs1_val & alu_b;
            end
            default: begin
                alu_ok = 1'b0;
                alu_res = '0;
            end
        endcase
    end

    always_comb begin
        take = 1'b0;
        case (f3)
            F3_BEQ: take = (i_rs1_val == i_rs2_val);
            F3_BNE: take = (i_rs1_val != i_rs2_val);
            F3_BLT: take = ($signed(i_rs1_val) < $signed(i_rs2_val));
            F3_BGE: take = !($signed(i_rs1_val) < $signed(i_rs2_val));
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        o_res = '0;
        o_res.status = ST_EXECUTED;
        o_res.new_pc = i_pc;
        legal = 1'b0;
        wr = 1'b0;
        res = '0;
        npc = seq_pc;
        addr = '0;
        if (i_mode) begin
            if (i_load_waiting) begin
                o_res.status = ST_LOAD_WR;
                o_res.load_clr = 1'b1;
                if (i_pending_dest != '0) begin
                    o_res.rf_we = 1'b1;
                    o_res.dest_index = i_pending_dest;
                    o_res.dest_value = i_load_data;
                end
            end else begin
                o_res.status = ST_IGNORED;
            end
        end else if (i_load_waiting) begin
            o_res.status = ST_IGNORED;
        end else begin
            case (op)
                OP_REG: begin
                    legal = ok_rd && ok_rs1 && ok_rs2 && alu_ok;
                    wr = 1'b1;
                    res = alu_res;
                end
                OP_IMM: begin
                    legal = ok_rd && ok_rs1 && alu_ok;
                    wr = 1'b1;
                    res = alu_res;
                end
                OP_LUI: begin
                    legal = ok_rd;
                    wr = 1'b1;
                    res = {i_instr[31:12], 12'b0};
                end
                OP_AUIPC: begin
                    legal = ok_rd;
                    wr = 1'b1;
                    res = i_pc + {i_instr[31:12], 12'b0};
                end
                OP_JAL: begin
                    legal = ok_rd;
                    wr = 1'b1;
                    res = seq_pc;
                    npc = i_pc + immj;
                end
                OP_JALR: begin
                    legal = (f3 == F3_JALR) && ok_rd && ok_rs1;
                    wr = 1'b1;
                    res = seq_pc;
                    addr = i_rs1_val + immi;
                    npc = {addr[XLEN-1:1], 1'b0};
                    addr = '0;
                end
                OP_BRANCH: begin
                    legal = ok_rs1 && ok_rs2 && (f3 == F3_BEQ || f3 == F3_BNE
                            || f3 == F3_BLT || f3 == F3_BGE);
                    npc = take ? (i_pc + immb) : seq_pc;
                end
                OP_LOAD: begin
                    legal = (f3 == F3_WORD) && ok_rd && ok_rs1;
                    if (legal) begin
                        addr = i_rs1_val + immi;
                        o_res.status = ST_LOAD_REQ;
                        o_res.mem_address = addr;
                        o_res.io_access = (addr == i_io_address);
                        o_res.load_set = 1'b1;
                        o_res.pend_dest = rd;
                    end
                end
                OP_STORE: begin
                    legal = (f3 == F3_WORD) && ok_rs1 && ok_rs2;
                    if (legal) begin
                        addr = i_rs1_val + imms;
                        o_res.status = ST_STORE;
                        o_res.mem_address = addr;
                        o_res.io_access = (addr == i_io_address);
                        o_res.store_data = i_rs2_val;
                    end
                end
                default: begin
                    legal = 1'b0;
                end
            endcase
            if (!legal) begin
                o_res.status = ST_ILLEGAL;
                o_res.mem_address = '0;
                o_res.io_access = 1'b0;
                o_res.store_data = '0;
                o_res.load_set = 1'b0;
                o_res.pend_dest = '0;
            end else begin
                o_res.pc_we = 1'b1;
                o_res.new_pc = npc;
                if (wr && rd != '0) begin
                    o_res.rf_we = 1'b1;
                    o_res.dest_index = rd;
                    o_res.dest_value = res;
                end
            end
        end
    end

endmodule

/* hdl/rv32i_subset_execute_unit.sv */
// Top level of the RV32I subset execute unit.
//
// Requests arrive on i_req: mode 0 carries an instruction word, mode 1 the data
// answering an earlier load request. Each request gives exactly one result on
// o_rsp with its status, memory address, store data, console flag, new program
// counter and the register it wrote.
// A request is taken when valid and ready are high at a clock edge. The source
// registers are read from the register file memory at that edge; the request
// then executes in the execute stage and its result is registered in the output
// register. One request per cycle is sustained while the receiver holds ready
// high; the write of one request is forwarded to the reads of the next.
// When the receiver holds ready low, the result waits in the output register
// and one more request waits in the execute stage; only then is ready low.
// Configuration writes on i_cfg_we set the console address (index 0) or the
// start address (index 1), which also loads the program counter; they are to be
// made only while the unit is idle; the unit does not enforce this. After reset
// the registers read zero, the program counter holds zero, no load is pending
// and the console address is reset; requests are taken in the first cycle after reset.
module rv32i_subset_execute_unit
    import rvx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [XLEN-1:0]       i_cfg_data,
    rvx_in_if.sink                i_req,
    rvx_out_if.source             o_rsp
);

    logic                 r_s1_valid;
    logic                 r_s1_mode;
    logic [XLEN-1:0]      r_s1_instr;
    logic [XLEN-1:0]      r_s1_load_data;
    logic                 r_out_valid;
    t_exec_res            r_out;
    logic [XLEN-1:0]      r_pc;
    logic [XLEN-1:0]      r_io_address;
    logic                 r_load_waiting;
    logic [REG_IDX_W-1:0] r_pending_dest;

    logic                 in_fire;
    logic                 s1_fire;
    logic [XLEN-1:0]      rs1_val;
    logic [XLEN-1:0]      rs2_val;
    t_exec_res            exec_res;

    assign s1_fire = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign in_fire = i_req.valid && i_req.ready;

    rvx_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rs1_idx (i_req.instr_word[19:15]),
        .i_rs2_idx (i_req.instr_word[24:20]),
        .i_wr_en   (s1_fire && exec_res.rf_we),
        .i_wr_idx  (exec_res.dest_index),
        .i_wr_data (exec_res.dest_value),
        .o_rs1_val (rs1_val),
        .o_rs2_val (rs2_val)
    );

    rvx_exec #(
        .NUM_REGS (NUM_REGS)
    ) u_exec (
        .i_mode         (r_s1_mode),
        .i_instr        (r_s1_instr),
        .i_load_data    (r_s1_load_data),
        .i_rs1_val      (rs1_val),
        .i_rs2_val      (rs2_val),
        .i_pc           (r_pc),
        .i_io_address   (r_io_address),
        .i_load_waiting (r_load_waiting),
        .i_pending_dest (r_pending_dest),
        .o_res          (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode <= i_req.mode;
            r_s1_instr <= i_req.instr_word;
            r_s1_load_data <= i_req.load_data;
        end
        if (s1_fire) begin
            r_out <= exec_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc <= START_PC_RESET;
            r_io_address <= IO_ADDRESS_RESET;
            r_load_waiting <= 1'b0;
            r_pending_dest <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && i_cfg_index == CFG_IO_ADDRESS) begin
                r_io_address <= i_cfg_data;
            end
            if (s1_fire && exec_res.pc_we) begin
                r_pc <= exec_res.new_pc;
            end else if (i_cfg_we && i_cfg_index == CFG_START_PC) begin
                r_pc <= i_cfg_data;
            end
            if (s1_fire && exec_res.load_set) begin
                r_load_waiting <= 1'b1;
                r_pending_dest <= exec_res.pend_dest;
            end else if (s1_fire && exec_res.load_clr) begin
                r_load_waiting <= 1'b0;
            end
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.status = r_out.status;
    assign o_rsp.mem_address = r_out.mem_address;
    assign o_rsp.store_data = r_out.store_data;
    assign o_rsp.io_access = r_out.io_access;
    assign o_rsp.new_pc = r_out.new_pc;
    assign o_rsp.dest_index = r_out.dest_index;
    assign o_rsp.dest_value = r_out.dest_value;

endmodule
